@@ sv/atcd_pkg.sv @@
// Shared types, constants and the header prefix table for the chunked download deframer.
`timescale 1ns / 1ps
`default_nettype none
package atcd_pkg;

  localparam int BLOCK_BYTES_DEF = 4096;
  localparam int COUNT_BITS_DEF  = 24;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [4:0]  HEADER_LIMIT = 5'd30;
  localparam logic [4:0]  PREFIX_LEN   = 5'd10;
  localparam logic [3:0]  WORD_LIMIT   = 4'd10;
  localparam logic [23:0] SIZE_SAT     = 24'hFFFFFF;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_HEADER,
    PH_DATA,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    NUM_SKIP,
    NUM_DIGITS,
    NUM_STOP
  } num_t;

  typedef enum logic [2:0] {
    WM_NONE,
    WM_O,
    WM_E,
    WM_ER,
    WM_ERR,
    WM_ERRO,
    WM_JUNK
  } word_t;

  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_OK    = 2'd1,
    ST_ERR   = 2'd2,
    ST_SHORT = 2'd3
  } status_t;

  typedef struct packed {
    logic       restart;
    logic [7:0] rx_byte;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_blank;
    logic       is_plus;
    logic       is_comma;
    logic       is_o;
    logic       is_e;
    logic       is_k;
    logic       is_r;
  } class_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        block_end;
    logic [11:0] tail_count;
    logic [23:0] bytes_received;
    status_t     status;
  } result_t;

  function automatic logic [7:0] prefix_char(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0: ch = 8'h2B;
      4'd1: ch = 8'h48;
      4'd2: ch = 8'h54;
      4'd3: ch = 8'h54;
      4'd4: ch = 8'h50;
      4'd5: ch = 8'h43;
      4'd6: ch = 8'h47;
      4'd7: ch = 8'h45;
      4'd8: ch = 8'h54;
      4'd9: ch = 8'h3A;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

@@ sv/at_chunked_download_deframer.sv @@
// Top level of the chunked download deframer for modem reply bytes.
// Bytes are registered in the middle queue, results in the result queue before the ports.
// Throughput: one byte per cycle if no queue is full; the parser updates once per byte.
// Queues of two entries sit between classifier and core and in front of the result port.
// Reset (rst, synchronous): parser idle, counts zero, status running, expected_total zero.
`timescale 1ns / 1ps
`default_nettype none
module at_chunked_download_deframer #(
  parameter int BLOCK_BYTES = atcd_pkg::BLOCK_BYTES_DEF,
  parameter int COUNT_BITS  = atcd_pkg::COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        req_type,
  input  wire logic [7:0]  rx_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic             payload_valid,
  output logic [7:0]       payload_byte,
  output logic             block_end,
  output logic [11:0]      tail_count,
  output logic [23:0]      bytes_received,
  output logic [1:0]       status,
  input  wire logic        expected_total_wen,
  input  wire logic [23:0] expected_total
);

  localparam int CLASS_W  = $bits(atcd_pkg::class_t);
  localparam int RESULT_W = $bits(atcd_pkg::result_t);

  logic [23:0]       exp_total;
  logic              mid_full;
  logic              mid_push;
  logic              mid_empty;
  logic              mid_pop;
  logic              back_ready;
  logic              res_push;
  logic              res_full;
  atcd_pkg::class_t  front_item;
  atcd_pkg::class_t  back_item;
  atcd_pkg::result_t back_result;
  atcd_pkg::result_t head_result;
  logic [CLASS_W-1:0]  mid_rdata;
  logic [RESULT_W-1:0] res_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_total <= '0;
    end else if (expected_total_wen) begin
      exp_total <= expected_total;
    end
  end

  atcd_front u_front (
    .push     (push),
    .req_type (req_type),
    .rx_byte  (rx_byte),
    .full     (full),
    .q_full   (mid_full),
    .q_push   (mid_push),
    .q_item   (front_item)
  );

  atcd_fifo #(
    .WIDTH (CLASS_W),
    .DEPTH (atcd_pkg::QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (front_item),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  assign back_item = mid_rdata;
  assign mid_pop   = back_ready && !mid_empty;

  atcd_back #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .expected_total (exp_total),
    .in_valid       (!mid_empty),
    .in_item        (back_item),
    .in_ready       (back_ready),
    .out_push       (res_push),
    .out_item       (back_result),
    .out_full       (res_full)
  );

  atcd_fifo #(
    .WIDTH (RESULT_W),
    .DEPTH (atcd_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (back_result),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign head_result    = res_rdata;
  assign payload_valid  = head_result.payload_valid;
  assign payload_byte   = head_result.payload_byte;
  assign block_end      = head_result.block_end;
  assign tail_count     = head_result.tail_count;
  assign bytes_received = head_result.bytes_received;
  assign status         = head_result.status;

endmodule
`default_nettype wire

@@ sv/atcd_fifo.sv @@
// Small synchronous queue used between front, back and the result port.
`timescale 1ns / 1ps
`default_nettype none
module atcd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = atcd_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == CNT_BITS'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/atcd_front.sv @@
// Input side: takes received bytes and classifies them for the parser.
`timescale 1ns / 1ps
`default_nettype none
module atcd_front (
  input  wire logic       push,
  input  wire logic       req_type,
  input  wire logic [7:0] rx_byte,
  output logic            full,
  input  wire logic       q_full,
  output logic            q_push,
  output atcd_pkg::class_t q_item
);

  logic is_digit;

  assign full     = q_full;
  assign q_push   = push && !q_full;
  assign is_digit = (rx_byte >= atcd_pkg::CH_ZERO) && (rx_byte <= atcd_pkg::CH_NINE);

  always_comb begin
    q_item.restart  = req_type;
    q_item.rx_byte  = rx_byte;
    q_item.is_digit = is_digit;
    q_item.digit    = rx_byte[3:0];
    q_item.is_blank = (rx_byte == atcd_pkg::CH_SPACE) ||
                      ((rx_byte >= atcd_pkg::CH_TAB) && (rx_byte <= atcd_pkg::CH_CR));
    q_item.is_plus  = (rx_byte == atcd_pkg::CH_PLUS);
    q_item.is_comma = (rx_byte == atcd_pkg::CH_COMMA);
    q_item.is_o     = (rx_byte == atcd_pkg::CH_O);
    q_item.is_e     = (rx_byte == atcd_pkg::CH_E);
    q_item.is_k     = (rx_byte == atcd_pkg::CH_K);
    q_item.is_r     = (rx_byte == atcd_pkg::CH_R);
  end

endmodule
`default_nettype wire

@@ sv/atcd_back.sv @@
// Parser core: header match, size parse, payload counting and final status.
`timescale 1ns / 1ps
`default_nettype none
module atcd_back #(
  parameter int BLOCK_BYTES = atcd_pkg::BLOCK_BYTES_DEF,
  parameter int COUNT_BITS  = atcd_pkg::COUNT_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [23:0]      expected_total,
  input  wire logic             in_valid,
  input  wire atcd_pkg::class_t in_item,
  output logic                  in_ready,
  output logic                  out_push,
  output atcd_pkg::result_t     out_item,
  input  wire logic             out_full
);

  localparam int POS_BITS = $clog2(BLOCK_BYTES);

  atcd_pkg::phase_t  parse_phase, parse_phase_next;
  atcd_pkg::num_t    number_phase, number_phase_next;
  atcd_pkg::word_t   word_match, word_match_next;
  atcd_pkg::status_t final_status, final_status_next;

  logic [4:0]            header_length, header_length_next;
  logic                  prefix_mismatch, prefix_mismatch_next;
  logic [23:0]           chunk_len, chunk_len_next;
  logic [23:0]           chunk_count, chunk_count_next;
  logic [POS_BITS-1:0]   block_position, block_position_next;
  logic [COUNT_BITS-1:0] total_count, total_count_next;
  logic [3:0]            inter_length, inter_length_next;

  logic                  step;
  logic                  to_wait;
  logic                  short_total;
  logic [POS_BITS:0]     pos_inc;
  logic [23:0]           cnt_inc;
  logic [4:0]            hl_inc;
  logic [3:0]            inter_inc;
  logic [27:0]           size_mul;
  logic [POS_BITS+11:0]  pos_ext;
  logic [COUNT_BITS+23:0] tot_ext;

  assign step     = in_valid && !out_full;
  assign in_ready = !out_full;
  assign out_push = step;

  assign pos_inc   = {1'b0, block_position} + 1'b1;
  assign cnt_inc   = chunk_count + 1'b1;
  assign hl_inc    = header_length + 1'b1;
  assign inter_inc = inter_length + 1'b1;
  assign size_mul  = ({4'b0, chunk_len} << 3) + ({4'b0, chunk_len} << 1) +
                     {24'b0, in_item.digit};
  assign short_total = (expected_total != '0) &&
                       ({24'b0, total_count} < {{COUNT_BITS{1'b0}}, expected_total});

  always_comb begin
    parse_phase_next     = parse_phase;
    number_phase_next    = number_phase;
    word_match_next      = word_match;
    final_status_next    = final_status;
    header_length_next   = header_length;
    prefix_mismatch_next = prefix_mismatch;
    chunk_len_next       = chunk_len;
    chunk_count_next     = chunk_count;
    block_position_next  = block_position;
    total_count_next     = total_count;
    inter_length_next    = inter_length;
    to_wait              = 1'b0;
    out_item.payload_valid = 1'b0;
    out_item.payload_byte  = 8'h00;
    out_item.block_end     = 1'b0;

    if (in_item.restart) begin
      to_wait           = 1'b1;
      chunk_len_next    = '0;
      chunk_count_next  = '0;
      block_position_next = '0;
      total_count_next  = '0;
      final_status_next = atcd_pkg::ST_RUN;
    end else begin
      case (parse_phase)
        atcd_pkg::PH_WAIT: begin
          if (in_item.is_plus) begin
            to_wait        = 1'b1;
            chunk_len_next = '0;
          end else if (in_item.is_o) begin
            if (word_match == atcd_pkg::WM_ERR) begin
              word_match_next   = atcd_pkg::WM_ERRO;
              inter_length_next = inter_inc;
            end else begin
              word_match_next   = atcd_pkg::WM_O;
              inter_length_next = 4'd1;
            end
          end else if (in_item.is_e) begin
            word_match_next   = atcd_pkg::WM_E;
            inter_length_next = 4'd1;
          end else if (word_match != atcd_pkg::WM_NONE) begin
            inter_length_next = inter_inc;
            if (word_match == atcd_pkg::WM_O && in_item.is_k) begin
              final_status_next = short_total ? atcd_pkg::ST_SHORT : atcd_pkg::ST_OK;
              parse_phase_next  = atcd_pkg::PH_DONE;
            end else if (word_match == atcd_pkg::WM_E && in_item.is_r) begin
              word_match_next = atcd_pkg::WM_ER;
            end else if (word_match == atcd_pkg::WM_ER && in_item.is_r) begin
              word_match_next = atcd_pkg::WM_ERR;
            end else if (word_match == atcd_pkg::WM_ERRO && in_item.is_r) begin
              final_status_next = atcd_pkg::ST_ERR;
              parse_phase_next  = atcd_pkg::PH_DONE;
            end else if (inter_inc > atcd_pkg::WORD_LIMIT) begin
              word_match_next   = atcd_pkg::WM_NONE;
              inter_length_next = '0;
            end else begin
              word_match_next = atcd_pkg::WM_JUNK;
            end
          end
        end
        atcd_pkg::PH_HEADER: begin
          header_length_next = hl_inc;
          if (header_length < atcd_pkg::PREFIX_LEN) begin
            if (in_item.rx_byte != atcd_pkg::prefix_char(header_length[3:0])) begin
              prefix_mismatch_next = 1'b1;
            end
          end else if (!prefix_mismatch && in_item.is_comma) begin
            if (chunk_len != '0) begin
              parse_phase_next = atcd_pkg::PH_DATA;
              chunk_count_next = '0;
            end else begin
              to_wait = 1'b1;
            end
          end else if (!prefix_mismatch) begin
            case (number_phase)
              atcd_pkg::NUM_SKIP: begin
                if (in_item.is_digit) begin
                  chunk_len_next    = {20'b0, in_item.digit};
                  number_phase_next = atcd_pkg::NUM_DIGITS;
                end else if (!in_item.is_blank) begin
                  number_phase_next = atcd_pkg::NUM_STOP;
                end
              end
              atcd_pkg::NUM_DIGITS: begin
                if (in_item.is_digit) begin
                  chunk_len_next = (size_mul[27:24] != '0) ? atcd_pkg::SIZE_SAT
                                                          : size_mul[23:0];
                end else begin
                  number_phase_next = atcd_pkg::NUM_STOP;
                end
              end
              default: begin
              end
            endcase
          end
          if (hl_inc > atcd_pkg::HEADER_LIMIT) begin
            to_wait = 1'b1;
          end
        end
        atcd_pkg::PH_DATA: begin
          out_item.payload_valid = 1'b1;
          out_item.payload_byte  = in_item.rx_byte;
          chunk_count_next       = cnt_inc;
          if (total_count != {COUNT_BITS{1'b1}}) begin
            total_count_next = total_count + 1'b1;
          end
          if (cnt_inc >= chunk_len) begin
            to_wait = 1'b1;
          end
          if (pos_inc >= (POS_BITS + 1)'(BLOCK_BYTES)) begin
            out_item.block_end  = 1'b1;
            block_position_next = '0;
          end else begin
            block_position_next = pos_inc[POS_BITS-1:0];
          end
        end
        default: begin
        end
      endcase
    end

    if (to_wait) begin
      parse_phase_next     = atcd_pkg::PH_WAIT;
      header_length_next   = '0;
      prefix_mismatch_next = 1'b0;
      number_phase_next    = atcd_pkg::NUM_SKIP;
      word_match_next      = atcd_pkg::WM_NONE;
      inter_length_next    = '0;
      if (!in_item.restart && parse_phase == atcd_pkg::PH_WAIT && in_item.is_plus) begin
        parse_phase_next   = atcd_pkg::PH_HEADER;
        header_length_next = 5'd1;
      end
    end

    pos_ext = {12'b0, block_position_next};
    tot_ext = {24'b0, total_count_next};
    out_item.tail_count     = pos_ext[11:0];
    out_item.bytes_received = tot_ext[23:0];
    out_item.status         = final_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= atcd_pkg::PH_WAIT;
    end else if (step) begin
      parse_phase <= parse_phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      number_phase    <= atcd_pkg::NUM_SKIP;
      word_match      <= atcd_pkg::WM_NONE;
      final_status    <= atcd_pkg::ST_RUN;
      header_length   <= '0;
      prefix_mismatch <= 1'b0;
      chunk_len       <= '0;
      chunk_count     <= '0;
      block_position  <= '0;
      total_count     <= '0;
      inter_length    <= '0;
    end else if (step) begin
      number_phase    <= number_phase_next;
      word_match      <= word_match_next;
      final_status    <= final_status_next;
      header_length   <= header_length_next;
      prefix_mismatch <= prefix_mismatch_next;
      chunk_len       <= chunk_len_next;
      chunk_count     <= chunk_count_next;
      block_position  <= block_position_next;
      total_count     <= total_count_next;
      inter_length    <= inter_length_next;
    end
  end

endmodule
`default_nettype wire
